@@ hw/rtl/assert_macros.svh @@
// Assertion macros shared by the RTL files.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication checked at every rising clock edge outside reset.
`define ATA_ASSERT(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Signal must be low at every rising clock edge outside reset.
`define ATA_ASSERT_NEVER(lbl, clk, rst, sig, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) !(sig)) else $error(msg);

`endif

@@ hw/rtl/ata_pkg.sv @@
// Constants, codes and the CORDIC arctangent table of the affine transform accumulator.
package ata_pkg;

   localparam int COORD_WIDTH  = 32;
   localparam int FRAC_BITS    = 16;
   localparam int ANGLE_WIDTH  = 16;
   localparam int CORDIC_STEPS = 24;

   localparam int OPND_WIDTH = COORD_WIDTH + 1;          // multiplier operand
   localparam int PROD_WIDTH = 2 * OPND_WIDTH;
   localparam int ACC_WIDTH  = PROD_WIDTH + 2;           // four terms
   localparam int CRD_WIDTH  = 34;                       // CORDIC datapath, Q2.30 plus guard

   localparam logic [CRD_WIDTH-1:0] CORDIC_X0 = CRD_WIDTH'(32'h26DD3B6A);

   typedef enum logic [2:0] {
      OP_RESET     = 3'd0,
      OP_TRANSLATE = 3'd1,
      OP_SCALE     = 3'd2,
      OP_ROTATE    = 3'd3,
      OP_APPLY     = 3'd4
   } opcode_type;

   localparam logic [1:0] AXIS_X = 2'd0;
   localparam logic [1:0] AXIS_Y = 2'd1;
   localparam logic [1:0] AXIS_Z = 2'd2;

   function automatic logic [31:0] atan_turn(input logic [4:0] idx);
      logic [31:0] r;
      unique case (idx)
         5'd0:  r = 32'h20000000;  5'd1:  r = 32'h12E4051E;
         5'd2:  r = 32'h09FB385B;  5'd3:  r = 32'h051111D4;
         5'd4:  r = 32'h028B0D43;  5'd5:  r = 32'h0145D7E1;
         5'd6:  r = 32'h00A2F61E;  5'd7:  r = 32'h00517C55;
         5'd8:  r = 32'h0028BE53;  5'd9:  r = 32'h00145F2F;
         5'd10: r = 32'h000A2F98;  5'd11: r = 32'h000517CC;
         5'd12: r = 32'h00028BE6;  5'd13: r = 32'h000145F3;
         5'd14: r = 32'h0000A2FA;  5'd15: r = 32'h0000517D;
         5'd16: r = 32'h000028BE;  5'd17: r = 32'h0000145F;
         5'd18: r = 32'h00000A30;  5'd19: r = 32'h00000518;
         5'd20: r = 32'h0000028C;  5'd21: r = 32'h00000146;
         5'd22: r = 32'h000000A3;  5'd23: r = 32'h00000051;
         default: r = 32'h0;
      endcase
      return r;
   endfunction

endpackage

@@ hw/rtl/affine_transform_accumulator_top.sv @@
// Affine transform accumulator: 3x4 Q16.16 matrix, one shared multiplier under a sequencer.
//
//  channel  | ports                         | handshake
//  ---------+-------------------------------+--------------------------------
//  request  | req_opcode .. req_angle       | taken when start & !busy
//  response | rsp_out_x .. rsp_saturated    | rsp_valid for one cycle
//
// Each matrix entry or output coordinate is 4 multiply-adds on the one multiplier
// plus a rounding step. Translate and scale recompute all 12 entries, apply the three
// output coordinates, rotate runs 24 CORDIC steps plus three compositions.
// busy is high from the cycle after a transaction until its work is done, not for OP_RESET.
// The receiver cannot stall; rsp_valid is high for exactly one cycle with each result.
// Synchronous reset restores the identity matrix.
`include "assert_macros.svh"

module affine_transform_accumulator_top (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                start,
   output logic                                busy,
   input  logic [2:0]                          req_opcode,
   input  logic [1:0]                          req_axis_select,
   input  logic signed [ata_pkg::COORD_WIDTH-1:0] req_vx,
   input  logic signed [ata_pkg::COORD_WIDTH-1:0] req_vy,
   input  logic signed [ata_pkg::COORD_WIDTH-1:0] req_vz,
   input  logic [ata_pkg::ANGLE_WIDTH-1:0]     req_angle,
   output logic                                rsp_valid,
   output logic signed [ata_pkg::COORD_WIDTH-1:0] rsp_out_x,
   output logic signed [ata_pkg::COORD_WIDTH-1:0] rsp_out_y,
   output logic signed [ata_pkg::COORD_WIDTH-1:0] rsp_out_z,
   output logic                                rsp_saturated
);

   localparam int CW = ata_pkg::COORD_WIDTH;
   localparam int OW = ata_pkg::OPND_WIDTH;
   localparam int PW = ata_pkg::PROD_WIDTH;
   localparam int AW = ata_pkg::ACC_WIDTH;
   localparam int ZW = ata_pkg::CRD_WIDTH;
   localparam int FB = ata_pkg::FRAC_BITS;
   localparam int GW = ata_pkg::ANGLE_WIDTH;

   localparam logic signed [OW-1:0] ONE_Q = OW'(1) << FB;
   localparam logic signed [CW-1:0] SAT_MAX = {1'b0, {(CW-1){1'b1}}};
   localparam logic signed [CW-1:0] SAT_MIN = {1'b1, {(CW-1){1'b0}}};

   typedef enum logic [1:0] {ST_IDLE, ST_CORDIC, ST_MAC, ST_RND} state_type;
   typedef enum logic [2:0] {K_TRANS_NEG, K_ROT, K_TRANS_POS, K_SCALE, K_APPLY} kind_type;

   state_type               state_ff;
   kind_type                kind_ff;
   logic [2:0]              k_ff;
   logic [1:0]              i_ff, j_ff, ax_a_ff, ax_b_ff, quad_ff;
   logic [4:0]              step_ff;
   logic signed [CW-1:0]    t_ff [12];
   logic signed [OW-1:0]    v_ff [3];
   logic signed [OW-1:0]    cos_ff, sin_ff;
   logic signed [CW-1:0]    tmp_ff [2];
   logic signed [PW-1:0]    prod_ff;
   logic signed [AW-1:0]    acc_ff;
   logic signed [ZW-1:0]    cx_ff, cy_ff, cz_ff;
   logic                    sat_ff;
   logic                    rsp_valid_ff, rsp_sat_ff;
   logic signed [CW-1:0]    rsp_x_ff, rsp_y_ff, rsp_z_ff;

   logic [1:0]              k2;
   logic [3:0]              rd_idx;
   logic signed [CW-1:0]    t_rd;
   logic signed [OW-1:0]    op_a, op_b, t_ext;
   logic signed [AW-1:0]    rnd_sum, rnd_sh;
   logic                    rnd_ok;
   logic signed [CW-1:0]    rnd_val;
   logic signed [ZW-1:0]    sh_x, sh_y, nx, ny, nz, atan_ext, cr_full, sr_full;
   logic signed [OW-1:0]    cr, sr;

   assign k2 = k_ff[1:0];

   // Single read port into the matrix registers
   always_comb begin
      rd_idx = (kind_ff == K_APPLY) ? {i_ff, k2} : {k2, j_ff};
      t_rd   = (rd_idx < 4'd12) ? t_ff[rd_idx] : '0;
      t_ext  = OW'(t_rd);
   end

   // Operand selection: A from the primitive matrix (or T for apply), B from T (or point)
   always_comb begin
      op_a = '0;
      op_b = '0;
      unique case (kind_ff)
         K_APPLY: begin
            op_a = t_ext;
            op_b = (k2 == 2'd3) ? ONE_Q : v_ff[k2];
         end
         K_SCALE: begin
            op_a = (k2 != 2'd3 && i_ff == k2) ? v_ff[i_ff] : '0;
         end
         K_TRANS_NEG, K_TRANS_POS: begin
            if (k2 == 2'd3)
               op_a = (kind_ff == K_TRANS_NEG) ? -v_ff[i_ff] : v_ff[i_ff];
            else
               op_a = (i_ff == k2) ? ONE_Q : '0;
         end
         K_ROT: begin
            if (k2 == 2'd3)
               op_a = '0;
            else if ((i_ff == ax_a_ff && k2 == ax_a_ff) || (i_ff == ax_b_ff && k2 == ax_b_ff))
               op_a = cos_ff;
            else if (i_ff == ax_a_ff && k2 == ax_b_ff)
               op_a = -sin_ff;
            else if (i_ff == ax_b_ff && k2 == ax_a_ff)
               op_a = sin_ff;
            else
               op_a = (i_ff == k2) ? ONE_Q : '0;
         end
         default: op_a = '0;
      endcase
      if (kind_ff != K_APPLY)
         op_b = (k2 == 2'd3) ? ((j_ff == 2'd3) ? ONE_Q : '0) : t_ext;
   end

   // Round half up, then saturate
   always_comb begin
      rnd_sum = acc_ff + (AW'(1) <<< (FB - 1));
      rnd_sh  = rnd_sum >>> FB;
      rnd_ok  = (&rnd_sh[AW-1:CW-1]) || !(|rnd_sh[AW-1:CW-1]);
      rnd_val = rnd_ok ? rnd_sh[CW-1:0] : (rnd_sh[AW-1] ? SAT_MIN : SAT_MAX);
   end

   // CORDIC step, floor shifts
   always_comb begin
      sh_x     = cx_ff >>> step_ff;
      sh_y     = cy_ff >>> step_ff;
      atan_ext = ZW'(ata_pkg::atan_turn(step_ff));
      if (!cz_ff[ZW-1]) begin
         nx = cx_ff - sh_y;
         ny = cy_ff + sh_x;
         nz = cz_ff - atan_ext;
      end else begin
         nx = cx_ff + sh_y;
         ny = cy_ff - sh_x;
         nz = cz_ff + atan_ext;
      end
      cr_full = (cx_ff + (ZW'(1) <<< (29 - FB))) >>> (30 - FB);
      sr_full = (cy_ff + (ZW'(1) <<< (29 - FB))) >>> (30 - FB);
      cr      = cr_full[OW-1:0];
      sr      = sr_full[OW-1:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         kind_ff      <= K_APPLY;
         k_ff         <= '0;
         i_ff         <= '0;
         j_ff         <= '0;
         for (int n = 0; n < 12; n++)
            t_ff[n] <= (n == 0 || n == 5 || n == 10) ? CW'(ONE_Q) : '0;
      end else begin
         // last rounding step of an apply issues the result
         rsp_valid_ff <= (state_ff == ST_RND) && (i_ff == 2'd2) && (kind_ff == K_APPLY);
         unique case (state_ff)
            ST_IDLE: begin
               if (start) begin
                  v_ff[0] <= OW'(req_vx);
                  v_ff[1] <= OW'(req_vy);
                  v_ff[2] <= OW'(req_vz);
                  k_ff    <= '0;
                  i_ff    <= '0;
                  j_ff    <= '0;
                  acc_ff  <= '0;
                  sat_ff  <= 1'b0;
                  priority case (req_opcode)
                     ata_pkg::OP_RESET: begin
                        for (int n = 0; n < 12; n++)
                           t_ff[n] <= (n == 0 || n == 5 || n == 10) ? CW'(ONE_Q) : '0;
                     end
                     ata_pkg::OP_TRANSLATE: begin
                        kind_ff  <= K_TRANS_POS;
                        state_ff <= ST_MAC;
                     end
                     ata_pkg::OP_SCALE: begin
                        kind_ff  <= K_SCALE;
                        state_ff <= ST_MAC;
                     end
                     ata_pkg::OP_ROTATE: begin
                        if (req_axis_select != 2'd3) begin
                           kind_ff  <= K_TRANS_NEG;
                           state_ff <= ST_CORDIC;
                           ax_a_ff  <= (req_axis_select == ata_pkg::AXIS_X) ? 2'd1 :
                                       (req_axis_select == ata_pkg::AXIS_Y) ? 2'd2 : 2'd0;
                           ax_b_ff  <= (req_axis_select == ata_pkg::AXIS_X) ? 2'd2 :
                                       (req_axis_select == ata_pkg::AXIS_Y) ? 2'd0 : 2'd1;
                           quad_ff  <= req_angle[GW-1:GW-2];
                           step_ff  <= '0;
                           cx_ff    <= ata_pkg::CORDIC_X0;
                           cy_ff    <= '0;
                           cz_ff    <= ZW'({req_angle[GW-3:0], {(32-GW){1'b0}}});
                        end
                     end
                     ata_pkg::OP_APPLY: begin
                        kind_ff  <= K_APPLY;
                        state_ff <= ST_MAC;
                     end
                     default: ;
                  endcase
               end
            end
            ST_CORDIC: begin
               if (step_ff == 5'(ata_pkg::CORDIC_STEPS)) begin
                  unique case (quad_ff)
                     2'd0: begin cos_ff <= cr;  sin_ff <= sr;  end
                     2'd1: begin cos_ff <= -sr; sin_ff <= cr;  end
                     2'd2: begin cos_ff <= -cr; sin_ff <= -sr; end
                     default: begin cos_ff <= sr; sin_ff <= -cr; end
                  endcase
                  state_ff <= ST_MAC;
               end else begin
                  cx_ff   <= nx;
                  cy_ff   <= ny;
                  cz_ff   <= nz;
                  step_ff <= step_ff + 5'd1;
               end
            end
            ST_MAC: begin
               // product of term k registered while term k-1 accumulates
               if (k_ff != 3'd4)
                  prod_ff <= op_a * op_b;
               if (k_ff != 3'd0)
                  acc_ff <= acc_ff + AW'(prod_ff);
               if (k_ff == 3'd4)
                  state_ff <= ST_RND;
               k_ff <= k_ff + 3'd1;
            end
            ST_RND: begin
               acc_ff   <= '0;
               k_ff     <= '0;
               if (i_ff != 2'd2) begin
                  tmp_ff[i_ff[0]] <= rnd_val;
                  sat_ff          <= sat_ff | !rnd_ok;
                  i_ff            <= i_ff + 2'd1;
                  state_ff        <= ST_MAC;
               end else if (kind_ff == K_APPLY) begin
                  rsp_x_ff     <= tmp_ff[0];
                  rsp_y_ff     <= tmp_ff[1];
                  rsp_z_ff     <= rnd_val;
                  rsp_sat_ff   <= sat_ff | !rnd_ok;
                  state_ff     <= ST_IDLE;
               end else begin
                  t_ff[{2'd0, j_ff}] <= tmp_ff[0];
                  t_ff[{2'd1, j_ff}] <= tmp_ff[1];
                  t_ff[{2'd2, j_ff}] <= rnd_val;
                  i_ff <= '0;
                  j_ff <= j_ff + 2'd1;
                  if (j_ff == 2'd3) begin
                     priority case (kind_ff)
                        K_TRANS_NEG: begin
                           kind_ff  <= K_ROT;
                           state_ff <= ST_MAC;
                        end
                        K_ROT: begin
                           kind_ff  <= K_TRANS_POS;
                           state_ff <= ST_MAC;
                        end
                        default:     state_ff <= ST_IDLE;
                     endcase
                  end else begin
                     state_ff <= ST_MAC;
                  end
               end
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

   assign busy          = (state_ff != ST_IDLE);
   assign rsp_valid     = rsp_valid_ff;
   assign rsp_out_x     = rsp_x_ff;
   assign rsp_out_y     = rsp_y_ff;
   assign rsp_out_z     = rsp_z_ff;
   assign rsp_saturated = rsp_sat_ff;

   `ATA_ASSERT(a_rsp_single, clock, reset, rsp_valid |=> !rsp_valid, "result held over a cycle")
   `ATA_ASSERT(a_apply_busy, clock, reset,
      (start && !busy && req_opcode == ata_pkg::OP_APPLY) |=> busy, "apply did not start")
   `ATA_ASSERT(a_rsp_idle, clock, reset, rsp_valid |-> (!busy && $past(state_ff == ST_RND)),
      "result outside the rounding step")
   `ATA_ASSERT_NEVER(a_k_range, clock, reset, (state_ff == ST_MAC && k_ff > 3'd4),
      "term counter out of range")

endmodule
